FILE: sv/netpbm_image_decoder_defines.svh
// Assertion macros for the netpbm image decoder.
// Included by RTL files that carry concurrent checks.
`ifndef NETPBM_IMAGE_DECODER_DEFINES_SVH
`define NETPBM_IMAGE_DECODER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define NID_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define NID_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define NID_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define NID_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

FILE: sv/nid_pkg.sv
// Package for the netpbm image decoder: result kinds,
// format codes and character classes. No dependencies.
`default_nettype none
package nid_pkg;
   localparam int DIM_BITS_DEF = 16;
   localparam logic [1:0] KIND_PIXEL  = 2'd0;
   localparam logic [1:0] KIND_HEADER = 2'd1;
   localparam logic [1:0] KIND_ERROR  = 2'd2;
   localparam logic [2:0] FMT_P1 = 3'd1;
   localparam logic [2:0] FMT_P2 = 3'd2;
   localparam logic [2:0] FMT_P3 = 3'd3;
   localparam logic [2:0] FMT_P4 = 3'd4;
   localparam logic [2:0] FMT_P5 = 3'd5;
   localparam logic [2:0] FMT_P6 = 3'd6;
   localparam logic [7:0] CH_HASH = 8'd35;
   localparam logic [7:0] CH_P    = 8'd80;
   localparam logic [7:0] CH_NL   = 8'd10;
   localparam logic [7:0] CH_ZERO = 8'd48;
   localparam logic [15:0] TOKEN_MAX = 16'hFFFF;

   function automatic logic is_space(input logic [7:0] c);
      return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'd48) && (c <= 8'd57);
   endfunction

   // Accumulate one decimal digit, saturating at the token maximum.
   function automatic logic [15:0] acc_digit(input logic [15:0] a, input logic [7:0] c);
      logic [19:0] s;
      s = {4'd0, a} * 20'd10 + {16'd0, c[3:0]};
      return (s > {4'd0, TOKEN_MAX}) ? TOKEN_MAX : s[15:0];
   endfunction
endpackage
`default_nettype wire

FILE: sv/netpbm_image_decoder.sv
// Top level of the netpbm image decoder: header parser, raster unpacker
// and shared restoring divider. Uses nid_pkg and the defines header.
//
//  channel | dir | handshake             | payload
//  req     | in  | req_valid/req_stall   | req_data_byte
//  rsp     | out | rsp_valid/rsp_stall   | kind, sample_value, dims, flags
//
// A header or raster byte that gives no result leaves the block idle for the next byte.
// A scaled grey or color sample passes through 24 steps of the shared divider,
// a saturate step and the emit state; the next byte is taken only once the
// sample has left the output register.
// A P4 byte gives up to 8 items, one a cycle while the output is not stalled.
// The input is stalled while a byte is in work or a result waits.
// Reset is synchronous and returns the parser to waiting for the magic.
`default_nettype none
`include "netpbm_image_decoder_defines.svh"
module netpbm_image_decoder #(
   parameter int DIM_BITS = nid_pkg::DIM_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_data_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_kind,
   output logic [7:0]       rsp_sample_value,
   output logic [15:0]      rsp_image_width,
   output logic [15:0]      rsp_image_height,
   output logic [1:0]       rsp_channel_count,
   output logic             rsp_last_of_run,
   output logic             rsp_image_done
);
   import nid_pkg::*;

   localparam logic [3:0] PH_MAGIC = 4'd0, PH_DIGIT = 4'd1, PH_MEND = 4'd2,
      PH_WIDTH = 4'd3, PH_HEIGHT = 4'd4, PH_MAXVAL = 4'd5, PH_RASTER = 4'd6;
   localparam logic [2:0] ST_IDLE = 3'd0, ST_DIV = 3'd1, ST_BITS = 3'd2,
      ST_OUT = 3'd3, ST_FIN = 3'd4;
   localparam logic [DIM_BITS-1:0] DIM_MAX = '1;
   localparam int SL_BITS = 2 * DIM_BITS + 2;

   logic [3:0]  phase_ff;
   logic [2:0]  fmt_ff;
   logic [15:0] tok_ff;
   logic        tstart_ff, cmt_ff;
   logic [DIM_BITS-1:0] wid_ff, hgt_ff, col_ff;
   logic [15:0] maxv_ff;
   logic [SL_BITS-1:0] left_ff;
   logic [2:0]  st_ff;
   logic [7:0]  byte_ff;
   logic [3:0]  bit_ff, bcnt_ff;
   // marks a header emit in ST_OUT
   logic        hdr_ff;
   // divider
   logic [23:0] dvd_ff;
   logic [16:0] rem_ff;
   logic [4:0]  step_ff;
   // output register
   logic        ov_ff;
   logic [1:0]  okind_ff, och_ff;
   logic [7:0]  oval_ff;
   logic [15:0] ow_ff, oh_ff;
   logic        olast_ff, odone_ff;
   // pending post-emit reset after an error or the image end
   logic        rst_after_ff;

   assign req_stall = (st_ff != ST_IDLE) || ov_ff;
   wire acc = req_valid && !req_stall;
   wire out_free = !ov_ff || !rsp_stall;
   wire out_load = out_free &&
      (st_ff == ST_BITS || st_ff == ST_OUT || st_ff == ST_FIN);

   assign rsp_valid = ov_ff;
   assign rsp_kind = okind_ff;
   assign rsp_sample_value = oval_ff;
   assign rsp_image_width = ow_ff;
   assign rsp_image_height = oh_ff;
   assign rsp_channel_count = och_ff;
   assign rsp_last_of_run = olast_ff;
   assign rsp_image_done = odone_ff;

   wire [1:0] chn = (fmt_ff == FMT_P3 || fmt_ff == FMT_P6) ? 2'd3 : 2'd1;
   wire [DIM_BITS-1:0] tok_dim = (tok_ff > 16'(DIM_MAX)) ?
      DIM_MAX : tok_ff[DIM_BITS-1:0];
   wire [SL_BITS-1:0] wh = SL_BITS'(wid_ff) * SL_BITS'(hgt_ff);
   wire [SL_BITS-1:0] left_dec = (left_ff != '0) ? left_ff - 1'b1 : left_ff;
   wire [DIM_BITS:0] wrem = {1'b0, wid_ff} - {1'b0, col_ff};
   wire [3:0] p4cnt = (wrem > (DIM_BITS+1)'(8)) ? 4'd8 : wrem[3:0];
   wire [16:0] rtry = {rem_ff[15:0], dvd_ff[23]} - {1'b0, maxv_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_MAGIC; fmt_ff <= '0; tok_ff <= '0; tstart_ff <= 1'b0;
         cmt_ff <= 1'b0; wid_ff <= '0; hgt_ff <= '0; maxv_ff <= 16'd1;
         left_ff <= '0; col_ff <= '0; st_ff <= ST_IDLE; ov_ff <= 1'b0;
         rst_after_ff <= 1'b0;
      end else begin
         // Drop the shown item once taken unless a new one replaces it
         if (ov_ff && !rsp_stall && !out_load) ov_ff <= 1'b0;
         unique case (st_ff)
            ST_IDLE: if (acc) begin
               // Parse one byte
               logic [7:0] c;
               logic lastt;
               c = req_data_byte;
               lastt = (phase_ff == PH_MAXVAL) ||
                  (phase_ff == PH_HEIGHT && (fmt_ff == FMT_P1 || fmt_ff == FMT_P4));
               byte_ff <= c;
               unique case (phase_ff) inside
                  PH_MAGIC: if (!is_space(c)) begin
                     if (c != CH_P) st_ff <= ST_FIN; else phase_ff <= PH_DIGIT;
                  end
                  PH_DIGIT: if (c < 8'd49 || c > 8'd54) st_ff <= ST_FIN;
                     else begin fmt_ff <= c[2:0]; phase_ff <= PH_MEND; end
                  PH_MEND: if (!is_space(c)) st_ff <= ST_FIN;
                     else begin
                        phase_ff <= PH_WIDTH; tok_ff <= '0; tstart_ff <= 1'b0;
                        cmt_ff <= 1'b0;
                     end
                  PH_WIDTH, PH_HEIGHT, PH_MAXVAL: begin
                     if (cmt_ff) begin
                        if (c == CH_NL) cmt_ff <= 1'b0;
                     end else if (is_digit(c)) begin
                        tok_ff <= acc_digit(tok_ff, c); tstart_ff <= 1'b1;
                     end else if (!tstart_ff) begin
                        if (c == CH_HASH) cmt_ff <= 1'b1;
                        else if (!is_space(c)) st_ff <= ST_FIN;
                     end else if (!lastt && !is_space(c) && c != CH_HASH) begin
                        st_ff <= ST_FIN;
                     end else begin
                        if (phase_ff == PH_WIDTH) wid_ff <= tok_dim;
                        else if (phase_ff == PH_HEIGHT) hgt_ff <= tok_dim;
                        else maxv_ff <= tok_ff;
                        tok_ff <= '0; tstart_ff <= 1'b0;
                        if (lastt) begin
                           phase_ff <= PH_RASTER; st_ff <= ST_OUT;
                           hdr_ff <= 1'b1;
                        end else begin
                           if (c == CH_HASH) cmt_ff <= 1'b1;
                           phase_ff <= phase_ff + 4'd1;
                        end
                     end
                  end
                  PH_RASTER: begin
                     unique case (fmt_ff) inside
                        FMT_P1: if (is_digit(c)) begin
                           dvd_ff <= {(c == CH_ZERO) ? 8'd255 : 8'd0, 16'd0};
                           st_ff <= ST_OUT; hdr_ff <= 1'b0;
                        end else if (!is_space(c)) st_ff <= ST_FIN;
                        FMT_P2, FMT_P3: if (is_digit(c)) begin
                           tok_ff <= acc_digit(tok_ff, c); tstart_ff <= 1'b1;
                        end else if (is_space(c)) begin
                           if (tstart_ff) begin
                              dvd_ff <= {tok_ff, 8'd0} - {8'd0, tok_ff};
                              rem_ff <= '0; step_ff <= '0; st_ff <= ST_DIV;
                              tok_ff <= '0; tstart_ff <= 1'b0;
                           end
                        end else st_ff <= ST_FIN;
                        FMT_P4: begin
                           bit_ff <= '0; bcnt_ff <= p4cnt;
                           if (col_ff + DIM_BITS'(p4cnt) >= wid_ff) col_ff <= '0;
                           else col_ff <= col_ff + DIM_BITS'(p4cnt);
                           if (p4cnt != 4'd0 && left_ff != '0) st_ff <= ST_BITS;
                        end
                        default: begin
                           dvd_ff <= {8'd0, c, 8'd0} - {16'd0, c};
                           rem_ff <= '0; step_ff <= '0; st_ff <= ST_DIV;
                        end
                     endcase
                  end
                  default: phase_ff <= PH_MAGIC;
               endcase
            end
            ST_DIV: begin
               // One restoring step per cycle on the shared divider
               if (step_ff == 5'd24) begin
                  dvd_ff <= {(dvd_ff[23:8] != 16'd0) ? 8'd255 : dvd_ff[7:0], 16'd0};
                  st_ff <= ST_OUT; hdr_ff <= 1'b0;
               end else begin
                  if (!rtry[16]) begin
                     rem_ff <= rtry; dvd_ff <= {dvd_ff[22:0], 1'b1};
                  end else begin
                     rem_ff <= {rem_ff[15:0], dvd_ff[23]}; dvd_ff <= {dvd_ff[22:0], 1'b0};
                  end
                  step_ff <= step_ff + 5'd1;
               end
            end
            ST_BITS: if (out_free) begin
               // Emit one P4 bit
               logic fin;
               fin = (bit_ff + 4'd1 == bcnt_ff) || (left_dec == '0);
               ov_ff <= 1'b1; okind_ff <= KIND_PIXEL;
               oval_ff <= byte_ff[3'd7 - bit_ff[2:0]] ? 8'd0 : 8'd255;
               ow_ff <= '0; oh_ff <= '0; och_ff <= '0;
               olast_ff <= fin; odone_ff <= (left_dec == '0);
               left_ff <= left_dec; bit_ff <= bit_ff + 4'd1;
               if (fin) begin
                  st_ff <= ST_IDLE;
                  if (left_dec == '0) begin
                     phase_ff <= PH_MAGIC; fmt_ff <= '0; wid_ff <= '0; hgt_ff <= '0;
                     maxv_ff <= 16'd1; col_ff <= '0; tok_ff <= '0; tstart_ff <= 1'b0;
                     cmt_ff <= 1'b0;
                  end
               end
            end
            ST_OUT: if (out_free) begin
               ov_ff <= 1'b1; olast_ff <= 1'b1; st_ff <= ST_IDLE;
               if (hdr_ff) begin
                  // Header item, or an error item for a bad maxval
                  if (maxv_ff == '0 || ((fmt_ff == FMT_P5 || fmt_ff == FMT_P6) &&
                        maxv_ff > 16'd255)) begin
                     okind_ff <= KIND_ERROR; oval_ff <= '0; ow_ff <= '0; oh_ff <= '0;
                     och_ff <= '0; odone_ff <= 1'b0; rst_after_ff <= 1'b1;
                  end else begin
                     logic [SL_BITS-1:0] n;
                     n = (chn == 2'd3) ? (wh << 1) + wh : wh;
                     okind_ff <= KIND_HEADER; oval_ff <= '0;
                     ow_ff <= 16'(wid_ff); oh_ff <= 16'(hgt_ff); och_ff <= chn;
                     odone_ff <= (n == '0); left_ff <= n; col_ff <= '0;
                     cmt_ff <= 1'b0; rst_after_ff <= (n == '0);
                  end
               end else begin
                  okind_ff <= KIND_PIXEL; oval_ff <= dvd_ff[23:16];
                  ow_ff <= '0; oh_ff <= '0; och_ff <= '0;
                  odone_ff <= (left_dec == '0); left_ff <= left_dec;
                  rst_after_ff <= (left_dec == '0);
               end
            end
            ST_FIN: if (out_free) begin
               ov_ff <= 1'b1; olast_ff <= 1'b1; okind_ff <= KIND_ERROR;
               oval_ff <= '0; ow_ff <= '0; oh_ff <= '0; och_ff <= '0;
               odone_ff <= 1'b0; rst_after_ff <= 1'b1; st_ff <= ST_IDLE;
            end
            default: st_ff <= ST_IDLE;
         endcase
         // Return to reset state after an error or the image end
         if (rst_after_ff) begin
            rst_after_ff <= 1'b0;
            phase_ff <= PH_MAGIC; fmt_ff <= '0; wid_ff <= '0; hgt_ff <= '0;
            maxv_ff <= 16'd1; col_ff <= '0; tok_ff <= '0; tstart_ff <= 1'b0;
            cmt_ff <= 1'b0; left_ff <= '0;
         end
      end
   end

   // rst_after_ff is set only with an item and cleared next cycle; the input
   // is stalled then because the item is still shown or was just taken.
   `NID_ASSERT_IMPL(a_no_acc_busy, clock, reset, st_ff != ST_IDLE, !acc,
      "item accepted while busy")
   `NID_ASSERT_IMPL(a_pix_only_raster, clock, reset,
      st_ff == ST_DIV, phase_ff == PH_RASTER, "divider runs outside raster")
   `NID_ASSERT_NEXT(a_rst_once, clock, reset, rst_after_ff, !rst_after_ff,
      "reset pulse held")
   `NID_ASSERT_IMPL(a_err_fields, clock, reset, ov_ff && okind_ff == KIND_ERROR,
      !odone_ff && olast_ff, "error item fields")
endmodule
`default_nettype wire
